FILE: rtl/matrix_to_scale_quaternion_core_defines.svh
// ----------------------------------------------------------------------------
// matrix_to_scale_quaternion_core defines
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef MATRIX_TO_SCALE_QUATERNION_CORE_DEFINES_SVH
`define MATRIX_TO_SCALE_QUATERNION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MTSQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mtsq check failed");

// next-cycle implication, sampled on clock, off during reset
`define MTSQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtsq check failed");

`endif

FILE: rtl/mtsq_pkg.sv
// ----------------------------------------------------------------------------
// mtsq_pkg
// shared widths, constants, types and the output conversion function
// ----------------------------------------------------------------------------
package mtsq_pkg;

   localparam int DATA_W         = 32;
   localparam int WORK_FRAC      = 30;
   localparam int QUAT_FRAC_BITS = 30;
   localparam int QUAT_SHIFT     = WORK_FRAC - QUAT_FRAC_BITS;

   // square root: 64-bit radicand, 32-bit root
   localparam int RAD_W  = 64;
   localparam int ROOT_W = RAD_W / 2;

   // divider: magnitude numerator, unsigned divisor, Q30 quotient
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_QUO_W = 32;

   // normalized elements and their sums in signed Q30
   localparam int NRM_W = 34;
   localparam logic signed [NRM_W-1:0] ONE_Q30   = 34'sh0_4000_0000;
   localparam logic signed [NRM_W-1:0] TRACE_MIN = 34'sd1074;

   localparam logic [DIV_QUO_W-1:0] QUAT_LIM = 32'h4000_0000;
   localparam logic [DATA_W-1:0]    QUAT_ONE = QUAT_LIM >> QUAT_SHIFT;

   // branch code doubles as the index of the component equal to r/2
   typedef enum logic [1:0] {
      BR_X     = 2'd0,
      BR_Y     = 2'd1,
      BR_Z     = 2'd2,
      BR_TRACE = 2'd3
   } branch_type;

   // saturate magnitude to 1.0, rescale, restore sign
   function automatic logic [DATA_W-1:0] to_quat(input logic neg,
                                                 input logic [DIV_QUO_W-1:0] mag);
      logic [DIV_QUO_W-1:0] m;
      m = (mag > QUAT_LIM) ? QUAT_LIM : mag;
      m = m >> QUAT_SHIFT;
      return neg ? DATA_W'(-m) : DATA_W'(m);
   endfunction

endpackage

FILE: rtl/mtsq_delay.sv
// ----------------------------------------------------------------------------
// mtsq_delay
// valid and sideband delay line that runs beside an arithmetic pipe
// ----------------------------------------------------------------------------
module mtsq_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               data_ff[i] <= in_data;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               data_ff[i] <= data_ff[i-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

FILE: rtl/mtsq_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// mtsq_sqrt_pipe
// floor integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module mtsq_sqrt_pipe #(
   parameter int RAD_W = mtsq_pkg::RAD_W
) (
   input  logic               clock,
   input  logic               en,
   input  logic [RAD_W-1:0]   rad,
   output logic [RAD_W/2-1:0] root
);

   localparam int RT_W   = RAD_W / 2;
   localparam int STAGES = RT_W;
   localparam int REM_W  = RT_W + 3;

   logic [REM_W-1:0] rem_ff  [STAGES];
   logic [REM_W-1:0] rem_in  [STAGES];
   logic [RT_W-1:0]  root_ff [STAGES];
   logic [RT_W-1:0]  root_in [STAGES];
   logic [RAD_W-1:0] rad_ff  [STAGES];
   logic [RAD_W-1:0] rad_in  [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [REM_W-1:0] rem_p;
      logic [RT_W-1:0]  root_p;
      logic [RAD_W-1:0] rad_p;
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign rad_p  = rad_ff[i-1];
      end

      // bring down two radicand bits, try 4*root+1
      assign rem_t      = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      assign trial      = REM_W'({root_p, 2'b01});
      assign ge         = rem_t >= trial;
      assign rem_in[i]  = ge ? rem_t - trial : rem_t;
      assign root_in[i] = {root_p[RT_W-2:0], ge};
      assign rad_in[i]  = {rad_p[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
         end
      end
   end

   assign root = root_ff[STAGES-1];

endmodule

FILE: rtl/mtsq_div_pipe.sv
// ----------------------------------------------------------------------------
// mtsq_div_pipe
// restoring divider for (num << FRAC) / den, one quotient bit per stage,
// saturating on overflow and giving zero for a zero divisor
// ----------------------------------------------------------------------------
module mtsq_div_pipe #(
   parameter int NUM_W = mtsq_pkg::DIV_NUM_W,
   parameter int DEN_W = mtsq_pkg::DIV_DEN_W,
   parameter int QUO_W = mtsq_pkg::DIV_QUO_W,
   parameter int FRAC  = mtsq_pkg::WORK_FRAC
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int STAGES = QUO_W;
   localparam int HI_SH  = QUO_W - FRAC;

   logic [DEN_W-1:0] rem_ff  [STAGES];
   logic [DEN_W-1:0] rem_in  [STAGES];
   logic [QUO_W-1:0] quo_ff  [STAGES];
   logic [QUO_W-1:0] quo_in  [STAGES];
   logic [QUO_W-1:0] feed_ff [STAGES];
   logic [QUO_W-1:0] feed_in [STAGES];
   logic [DEN_W-1:0] den_ff  [STAGES];
   logic [DEN_W-1:0] den_in  [STAGES];
   logic             ovf_ff  [STAGES];
   logic             ovf_in  [STAGES];
   logic             dz_ff   [STAGES];
   logic             dz_in   [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [DEN_W-1:0] rem_p;
      logic [QUO_W-1:0] quo_p;
      logic [QUO_W-1:0] feed_p;
      logic [DEN_W-1:0] den_p;
      logic             ovf_p;
      logic             dz_p;
      logic [DEN_W:0]   rem_t;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (i == 0) begin : g_first
         // quotient of 2^QUO_W or more shows in the high part alone
         assign rem_p  = DEN_W'(num >> HI_SH);
         assign quo_p  = '0;
         assign feed_p = {num[HI_SH-1:0], FRAC'(0)};
         assign den_p  = den;
         assign ovf_p  = (num >> HI_SH) >= NUM_W'(den);
         assign dz_p   = den == '0;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign quo_p  = quo_ff[i-1];
         assign feed_p = feed_ff[i-1];
         assign den_p  = den_ff[i-1];
         assign ovf_p  = ovf_ff[i-1];
         assign dz_p   = dz_ff[i-1];
      end

      assign rem_t      = {rem_p, feed_p[QUO_W-1]};
      assign diff       = rem_t - {1'b0, den_p};
      assign ge         = rem_t >= {1'b0, den_p};
      assign rem_in[i]  = ge ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
      assign quo_in[i]  = {quo_p[QUO_W-2:0], ge};
      assign feed_in[i] = {feed_p[QUO_W-2:0], 1'b0};
      assign den_in[i]  = den_p;
      assign ovf_in[i]  = ovf_p;
      assign dz_in[i]   = dz_p;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            feed_ff[i] <= feed_in[i];
            den_ff[i]  <= den_in[i];
            ovf_ff[i]  <= ovf_in[i];
            dz_ff[i]   <= dz_in[i];
         end
      end
   end

   assign quo = dz_ff[STAGES-1]  ? '0 :
                ovf_ff[STAGES-1] ? '1 : quo_ff[STAGES-1];

endmodule

FILE: rtl/matrix_to_scale_quaternion_core.sv
// ----------------------------------------------------------------------------
// matrix_to_scale_quaternion_core
// splits a 3x4 affine matrix into translation, row scales and a unit
// rotation quaternion, fully pipelined
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   row0..row2 x/y/z, move x/y/z
//   rsp_      out         rsp_valid / rsp_ready   trans, scale, quat, degenerate
//
// one transaction enters per cycle while rsp_ready does not stall; most of
// the depth is in the two square root and two divider pipes, 32 stages each
// no state is kept between transactions; reset clears only the valid bits
// a stall on rsp_ready freezes every stage together, and req_ready drops in
// the same cycle, so nothing is dropped or repeated
//
module matrix_to_scale_quaternion_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row0_x,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row0_y,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row0_z,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row1_x,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row1_y,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row1_z,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row2_x,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row2_y,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_row2_z,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_move_x,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_move_y,
   input  logic signed [mtsq_pkg::DATA_W-1:0]    req_move_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_trans_x,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_trans_y,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_trans_z,
   output logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_x,
   output logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_y,
   output logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_z,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_x,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_y,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_z,
   output logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_w,
   output logic                                  rsp_degenerate
);

   import mtsq_pkg::*;

   localparam int SQRT_DEPTH = ROOT_W;
   localparam int DIV_DEPTH  = DIV_QUO_W;

   // sideband carried beside the first square root (row lengths)
   typedef struct packed {
      logic [8:0][DATA_W-1:0] v;
      logic [2:0][DATA_W-1:0] tr;
      logic                   degen;
   } side_a_type;

   // beside the row normalizing dividers
   typedef struct packed {
      logic [8:0]             neg;
      logic [2:0][DATA_W-1:0] len;
      logic [2:0][DATA_W-1:0] tr;
      logic                   degen;
   } side_b_type;

   // beside the quaternion square root
   typedef struct packed {
      logic [2:0]                nneg;
      logic [2:0][DIV_NUM_W-1:0] nmag;
      branch_type                br;
      logic [2:0][DATA_W-1:0]    len;
      logic [2:0][DATA_W-1:0]    tr;
      logic                      degen;
   } side_c_type;

   // beside the quaternion dividers
   typedef struct packed {
      logic [2:0]             nneg;
      branch_type             br;
      logic [DIV_QUO_W-1:0]   half;
      logic [2:0][DATA_W-1:0] len;
      logic [2:0][DATA_W-1:0] tr;
      logic                   degen;
   } side_d_type;

   // whole pipe advances together whenever the output register can move
   logic en;

   // ---------------- input stage: magnitudes and squares ----------------
   logic signed [DATA_W-1:0] in_m   [9];
   logic        [DATA_W-1:0] in_mag [9];

   logic                     a0_valid_ff;
   logic [RAD_W-1:0]         a0_sq_ff   [9];
   logic [DATA_W-1:0]        a0_v_ff    [9];
   logic [DATA_W-1:0]        a0_tr_ff   [3];
   logic [2:0]               a0_zero_ff;

   // ---------------- row sums of squares ----------------
   logic                     a1_valid_ff;
   logic [RAD_W-1:0]         a1_sum_ff  [3];
   side_a_type               a1_side_ff;

   // ---------------- row length and normalize ----------------
   logic [ROOT_W-1:0]        len_root   [3];
   side_a_type               da_side;
   logic                     da_valid;
   side_b_type               db_in;
   side_b_type               db_side;
   logic                     db_valid;
   logic [DIV_QUO_W-1:0]     nrm_quo    [9];

   logic                     n_valid_ff;
   logic signed [NRM_W-1:0]  n_ff       [9];
   logic [2:0][DATA_W-1:0]   n_len_ff;
   logic [2:0][DATA_W-1:0]   n_tr_ff;
   logic                     n_degen_ff;

   // ---------------- trace and candidate terms ----------------
   logic                     q0_valid_ff;
   logic signed [NRM_W-1:0]  q0_t_ff;
   logic signed [NRM_W-1:0]  q0_arg_ff  [3];
   logic signed [NRM_W-1:0]  q0_d12m21_ff;
   logic signed [NRM_W-1:0]  q0_d20m02_ff;
   logic signed [NRM_W-1:0]  q0_d01m10_ff;
   logic signed [NRM_W-1:0]  q0_s01p10_ff;
   logic signed [NRM_W-1:0]  q0_s20p02_ff;
   logic signed [NRM_W-1:0]  q0_s12p21_ff;
   logic                     q0_g00_11_ff;
   logic                     q0_g00_22_ff;
   logic                     q0_g11_22_ff;
   logic [2:0][DATA_W-1:0]   q0_len_ff;
   logic [2:0][DATA_W-1:0]   q0_tr_ff;
   logic                     q0_degen_ff;

   // ---------------- branch select ----------------
   branch_type               br_in;
   logic signed [NRM_W-1:0]  arg_sel;
   logic signed [NRM_W-1:0]  num_sel    [3];
   logic [RAD_W-1:0]         rad_in;

   logic                     q1_valid_ff;
   logic [RAD_W-1:0]         q1_rad_ff;
   side_c_type               q1_side_ff;
   side_c_type               q1_side_in;

   // ---------------- quaternion root and divides ----------------
   logic [ROOT_W-1:0]        q_root;
   side_c_type               dc_side;
   logic                     dc_valid;
   side_d_type               dd_in;
   side_d_type               dd_side;
   logic                     dd_valid;
   logic [DIV_QUO_W-1:0]     q_quo      [3];

   // ---------------- output register ----------------
   logic [DATA_W-1:0]        quat_in    [4];

   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_tr_ff  [3];
   logic [DATA_W-1:0]        rsp_len_ff [3];
   logic [DATA_W-1:0]        rsp_quat_ff[4];
   logic                     rsp_degen_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign in_m = '{req_row0_x, req_row0_y, req_row0_z,
                   req_row1_x, req_row1_y, req_row1_z,
                   req_row2_x, req_row2_y, req_row2_z};

   // most negative input maps to 2^31, which the unsigned magnitude holds
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         in_mag[i] = in_m[i][DATA_W-1] ? DATA_W'(-in_m[i]) : DATA_W'(in_m[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_valid_ff <= 1'b0;
         a1_valid_ff <= 1'b0;
         n_valid_ff  <= 1'b0;
         q0_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
      end else if (en) begin
         a0_valid_ff <= req_valid;
         a1_valid_ff <= a0_valid_ff;
         n_valid_ff  <= db_valid;
         q0_valid_ff <= n_valid_ff;
         q1_valid_ff <= q0_valid_ff;
      end
   end

   // one 32x32 multiplier per element
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            a0_sq_ff[i] <= RAD_W'(in_mag[i]) * RAD_W'(in_mag[i]);
            a0_v_ff[i]  <= in_m[i];
         end
         a0_tr_ff[0] <= req_move_x;
         a0_tr_ff[1] <= req_move_y;
         a0_tr_ff[2] <= req_move_z;
         for (int r = 0; r < 3; r++) begin
            a0_zero_ff[r] <= (in_m[3*r] == '0) && (in_m[3*r+1] == '0) &&
                             (in_m[3*r+2] == '0);
         end
      end
   end

   // three squares of at most 2^62 each, so the sum fits in 64 bits
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            a1_sum_ff[r] <= a0_sq_ff[3*r] + a0_sq_ff[3*r+1] + a0_sq_ff[3*r+2];
         end
         for (int i = 0; i < 9; i++) begin
            a1_side_ff.v[i] <= a0_v_ff[i];
         end
         for (int r = 0; r < 3; r++) begin
            a1_side_ff.tr[r] <= a0_tr_ff[r];
         end
         a1_side_ff.degen <= |a0_zero_ff;
      end
   end

   // row lengths
   for (genvar r = 0; r < 3; r++) begin : g_len
      mtsq_sqrt_pipe #(
         .RAD_W (RAD_W)
      ) u_sqrt_len (
         .clock (clock),
         .en    (en),
         .rad   (a1_sum_ff[r]),
         .root  (len_root[r])
      );
   end

   mtsq_delay #(
      .WIDTH ($bits(side_a_type)),
      .DEPTH (SQRT_DEPTH)
   ) u_delay_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a1_valid_ff),
      .in_data   (a1_side_ff),
      .out_valid (da_valid),
      .out_data  (da_side)
   );

   // each element over its row length; |v| never exceeds the length,
   // so the quotient stays within 1.0
   for (genvar i = 0; i < 9; i++) begin : g_nrm
      logic [DATA_W-1:0] vmag;

      assign vmag = da_side.v[i][DATA_W-1] ? DATA_W'(-da_side.v[i]) : da_side.v[i];

      mtsq_div_pipe #(
         .NUM_W (DIV_NUM_W),
         .DEN_W (DIV_DEN_W),
         .QUO_W (DIV_QUO_W),
         .FRAC  (WORK_FRAC)
      ) u_div_nrm (
         .clock (clock),
         .en    (en),
         .num   (DIV_NUM_W'(vmag)),
         .den   (DIV_DEN_W'(len_root[i/3])),
         .quo   (nrm_quo[i])
      );
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         db_in.neg[i] = da_side.v[i][DATA_W-1];
      end
      for (int r = 0; r < 3; r++) begin
         db_in.len[r] = len_root[r];
      end
      db_in.tr    = da_side.tr;
      db_in.degen = da_side.degen;
   end

   mtsq_delay #(
      .WIDTH ($bits(side_b_type)),
      .DEPTH (DIV_DEPTH)
   ) u_delay_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (da_valid),
      .in_data   (db_in),
      .out_valid (db_valid),
      .out_data  (db_side)
   );

   // signed normalized elements
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            n_ff[i] <= db_side.neg[i] ? -NRM_W'(nrm_quo[i]) : NRM_W'(nrm_quo[i]);
         end
         n_len_ff   <= db_side.len;
         n_tr_ff    <= db_side.tr;
         n_degen_ff <= db_side.degen;
      end
   end

   // trace, the three diagonal arguments, and all sums and differences
   always_ff @(posedge clock) begin
      if (en) begin
         q0_t_ff      <= ONE_Q30 + n_ff[0] + n_ff[4] + n_ff[8];
         q0_arg_ff[0] <= ONE_Q30 + n_ff[0] - n_ff[4] - n_ff[8];
         q0_arg_ff[1] <= ONE_Q30 + n_ff[4] - n_ff[0] - n_ff[8];
         q0_arg_ff[2] <= ONE_Q30 + n_ff[8] - n_ff[0] - n_ff[4];
         q0_d12m21_ff <= n_ff[5] - n_ff[7];
         q0_d20m02_ff <= n_ff[6] - n_ff[2];
         q0_d01m10_ff <= n_ff[1] - n_ff[3];
         q0_s01p10_ff <= n_ff[1] + n_ff[3];
         q0_s20p02_ff <= n_ff[6] + n_ff[2];
         q0_s12p21_ff <= n_ff[5] + n_ff[7];
         q0_g00_11_ff <= n_ff[0] > n_ff[4];
         q0_g00_22_ff <= n_ff[0] > n_ff[8];
         q0_g11_22_ff <= n_ff[4] > n_ff[8];
         q0_len_ff    <= n_len_ff;
         q0_tr_ff     <= n_tr_ff;
         q0_degen_ff  <= n_degen_ff;
      end
   end

   // pick the branch: trace when 1+trace is not tiny, else the strictly
   // largest diagonal with ties falling to the later row
   always_comb begin
      if (q0_t_ff >= TRACE_MIN) begin
         br_in      = BR_TRACE;
         arg_sel    = q0_t_ff;
         num_sel[0] = q0_d12m21_ff;
         num_sel[1] = q0_d20m02_ff;
         num_sel[2] = q0_d01m10_ff;
      end else if (q0_g00_11_ff && q0_g00_22_ff) begin
         br_in      = BR_X;
         arg_sel    = q0_arg_ff[0];
         num_sel[0] = q0_s01p10_ff;
         num_sel[1] = q0_s20p02_ff;
         num_sel[2] = q0_d12m21_ff;
      end else if (q0_g11_22_ff) begin
         br_in      = BR_Y;
         arg_sel    = q0_arg_ff[1];
         num_sel[0] = q0_s01p10_ff;
         num_sel[1] = q0_s12p21_ff;
         num_sel[2] = q0_d20m02_ff;
      end else begin
         br_in      = BR_Z;
         arg_sel    = q0_arg_ff[2];
         num_sel[0] = q0_s20p02_ff;
         num_sel[1] = q0_s12p21_ff;
         num_sel[2] = q0_d01m10_ff;
      end
      // non-positive argument takes the root of zero
      rad_in = (arg_sel > 0) ? (RAD_W'(arg_sel[NRM_W-2:0]) << WORK_FRAC) : '0;
      for (int k = 0; k < 3; k++) begin
         q1_side_in.nneg[k] = num_sel[k][NRM_W-1];
         q1_side_in.nmag[k] = num_sel[k][NRM_W-1] ? DIV_NUM_W'(-num_sel[k]) :
                                                    DIV_NUM_W'(num_sel[k]);
      end
      q1_side_in.br    = br_in;
      q1_side_in.len   = q0_len_ff;
      q1_side_in.tr    = q0_tr_ff;
      q1_side_in.degen = q0_degen_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_rad_ff  <= rad_in;
         q1_side_ff <= q1_side_in;
      end
   end

   mtsq_sqrt_pipe #(
      .RAD_W (RAD_W)
   ) u_sqrt_quat (
      .clock (clock),
      .en    (en),
      .rad   (q1_rad_ff),
      .root  (q_root)
   );

   mtsq_delay #(
      .WIDTH ($bits(side_c_type)),
      .DEPTH (SQRT_DEPTH)
   ) u_delay_c (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q1_valid_ff),
      .in_data   (q1_side_ff),
      .out_valid (dc_valid),
      .out_data  (dc_side)
   );

   // off-branch components over 2r; quotient saturates past 1.0 anyway
   for (genvar k = 0; k < 3; k++) begin : g_qdiv
      mtsq_div_pipe #(
         .NUM_W (DIV_NUM_W),
         .DEN_W (DIV_DEN_W),
         .QUO_W (DIV_QUO_W),
         .FRAC  (WORK_FRAC)
      ) u_div_quat (
         .clock (clock),
         .en    (en),
         .num   (dc_side.nmag[k]),
         .den   ({q_root, 1'b0}),
         .quo   (q_quo[k])
      );
   end

   always_comb begin
      dd_in.nneg  = dc_side.nneg;
      dd_in.br    = dc_side.br;
      dd_in.half  = DIV_QUO_W'(q_root >> 1);
      dd_in.len   = dc_side.len;
      dd_in.tr    = dc_side.tr;
      dd_in.degen = dc_side.degen;
   end

   mtsq_delay #(
      .WIDTH ($bits(side_d_type)),
      .DEPTH (DIV_DEPTH)
   ) u_delay_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dc_valid),
      .in_data   (dd_in),
      .out_valid (dd_valid),
      .out_data  (dd_side)
   );

   // the branch index gets r/2, the other components take the quotients
   // in order; degenerate input gives the identity
   always_comb begin
      logic [1:0] k;
      logic [1:0] idx;
      k = dd_side.br;
      for (int j = 0; j < 4; j++) begin
         idx = (2'(j) < k) ? 2'(j) : 2'(j - 1);
         if (dd_side.degen) begin
            quat_in[j] = (j == 3) ? to_quat(1'b0, QUAT_LIM) : '0;
         end else if (2'(j) == k) begin
            quat_in[j] = to_quat(1'b0, dd_side.half);
         end else begin
            quat_in[j] = to_quat(dd_side.nneg[idx], q_quo[idx]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            rsp_tr_ff[r]  <= dd_side.tr[r];
            rsp_len_ff[r] <= dd_side.len[r];
         end
         for (int j = 0; j < 4; j++) begin
            rsp_quat_ff[j] <= quat_in[j];
         end
         rsp_degen_ff <= dd_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trans_x    = rsp_tr_ff[0];
   assign rsp_trans_y    = rsp_tr_ff[1];
   assign rsp_trans_z    = rsp_tr_ff[2];
   assign rsp_scale_x    = rsp_len_ff[0];
   assign rsp_scale_y    = rsp_len_ff[1];
   assign rsp_scale_z    = rsp_len_ff[2];
   assign rsp_quat_x     = rsp_quat_ff[0];
   assign rsp_quat_y     = rsp_quat_ff[1];
   assign rsp_quat_z     = rsp_quat_ff[2];
   assign rsp_quat_w     = rsp_quat_ff[3];
   assign rsp_degenerate = rsp_degen_ff;

endmodule

FILE: rtl/mtsq_checker.sv
// ----------------------------------------------------------------------------
// mtsq_checker
// port-level checks of the core, attached by bind
// ----------------------------------------------------------------------------
`include "matrix_to_scale_quaternion_core_defines.svh"

module mtsq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_x,
   input logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_y,
   input logic        [mtsq_pkg::DATA_W-1:0]    rsp_scale_z,
   input logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_x,
   input logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_y,
   input logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_z,
   input logic signed [mtsq_pkg::DATA_W-1:0]    rsp_quat_w,
   input logic                                  rsp_degenerate
);

   import mtsq_pkg::*;

   // stalled result stays valid, with quat_w and scale_x held
   `MTSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quat_w) && $stable(rsp_scale_x))

   // input side stalls exactly when the output register cannot drain
   `MTSQ_ASSERT_NOW(a_ready_follows, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   // degenerate flag matches an empty row
   `MTSQ_ASSERT_NOW(a_degen_scale, rsp_valid, rsp_degenerate == (rsp_scale_x == '0 || rsp_scale_y == '0 || rsp_scale_z == '0))

   // degenerate transaction carries the identity rotation
   `MTSQ_ASSERT_NOW(a_degen_ident, rsp_valid && rsp_degenerate, rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0 && rsp_quat_w == QUAT_ONE)

endmodule

bind matrix_to_scale_quaternion_core mtsq_checker u_mtsq_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for matrix_to_scale_quaternion_core: directed and
// random affine matrices, predicted results compared field by field
// ----------------------------------------------------------------------------
module tb_top;
   import mtsq_pkg::*;

   // one matrix transaction: rows 0..2 x/y/z, then move x/y/z
   typedef logic signed [31:0] matrix_type [12];

   // one decomposition result as it leaves the block
   typedef struct {
      logic [31:0] trans_x, trans_y, trans_z;
      logic [31:0] scale_x, scale_y, scale_z;
      logic [31:0] quat_x, quat_y, quat_z, quat_w;
      logic        degenerate;
   } decomposition_type;

   localparam longint ONE_WORK  = 64'sd1 << 30;
   localparam int     CYCLE_CAP = 400000;
   // idle wait after the last result, before the summary is printed
   localparam int     DRAIN_CYCLES = 160;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_field [12];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_trans_x, rsp_trans_y, rsp_trans_z;
   logic [31:0] rsp_scale_x, rsp_scale_y, rsp_scale_z;
   logic signed [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic rsp_degenerate;

   decomposition_type pending_results[$];
   int  error_count = 0;
   int  matrices_sent = 0;
   int  results_checked = 0;
   int  degenerate_seen = 0;
   int  branch_hits [4] = '{0, 0, 0, 0};
   int  cycle_count = 0;
   bit  idle_on = 1'b1;

   initial begin
      for (int i = 0; i < 12; i++) req_field[i] = '0;
   end

   always #1 clock = ~clock;

   matrix_to_scale_quaternion_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_row0_x(req_field[0]), .req_row0_y(req_field[1]), .req_row0_z(req_field[2]),
      .req_row1_x(req_field[3]), .req_row1_y(req_field[4]), .req_row1_z(req_field[5]),
      .req_row2_x(req_field[6]), .req_row2_y(req_field[7]), .req_row2_z(req_field[8]),
      .req_move_x(req_field[9]), .req_move_y(req_field[10]), .req_move_z(req_field[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_trans_x(rsp_trans_x), .rsp_trans_y(rsp_trans_y), .rsp_trans_z(rsp_trans_z),
      .rsp_scale_x(rsp_scale_x), .rsp_scale_y(rsp_scale_y), .rsp_scale_z(rsp_scale_z),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_quat_w(rsp_quat_w), .rsp_degenerate(rsp_degenerate)
   );

   // ------------------------------------------------------------------
   // fixed-point helpers of the predictor
   // ------------------------------------------------------------------

   // floor square root of a 64-bit unsigned value
   function automatic bit [63:0] floor_root(input bit [63:0] radicand);
      bit [63:0] root, probe, rest;
      root  = 0;
      rest  = radicand;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic bit [63:0] magnitude(input longint value);
      return (value < 0) ? 64'd0 - 64'(value) : 64'(value);
   endfunction

   // sign(num) * floor(|num| * 2^30 / den), capped at 2^40, zero for den 0
   function automatic longint q30_quotient(input longint num, input bit [63:0] den);
      bit [63:0] quo;
      if (den == 0) return 0;
      quo = (magnitude(num) << 30) / den;
      if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
      return (num < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   // saturate to 1.0, rescale to the output format, restore the sign
   function automatic logic [31:0] quat_field(input longint value);
      bit [63:0] mag;
      mag = magnitude(value);
      if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
      mag = mag >> (30 - QUAT_FRAC_BITS);
      if (value < 0) mag = 64'd0 - mag;
      return mag[31:0];
   endfunction

   // ------------------------------------------------------------------
   // predictor: scale extraction, row normalization, branch selection
   // ------------------------------------------------------------------
   function automatic decomposition_type decompose(input matrix_type mx,
                                                   output branch_type br);
      decomposition_type res;
      longint nrm [3][3];
      longint quat [4];
      bit [63:0] row_len [3];
      bit [63:0] sq_sum, root, twice;
      longint tr, arg;
      bit flat;
      flat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sq_sum = 0;
         for (int j = 0; j < 3; j++)
            sq_sum += magnitude(longint'(mx[i*3+j])) * magnitude(longint'(mx[i*3+j]));
         row_len[i] = floor_root(sq_sum);
         if (sq_sum == 0) flat = 1'b1;
         for (int j = 0; j < 3; j++)
            nrm[i][j] = q30_quotient(longint'(mx[i*3+j]), row_len[i]);
      end
      br = BR_TRACE;
      if (flat) begin
         quat = '{0, 0, 0, ONE_WORK};
      end else begin
         tr = ONE_WORK + nrm[0][0] + nrm[1][1] + nrm[2][2];
         if (tr >= 1074) begin
            root  = floor_root(64'(tr) << 30);
            twice = root << 1;
            quat[0] = q30_quotient(nrm[1][2] - nrm[2][1], twice);
            quat[1] = q30_quotient(nrm[2][0] - nrm[0][2], twice);
            quat[2] = q30_quotient(nrm[0][1] - nrm[1][0], twice);
            quat[3] = longint'(root >> 1);
         end else if (nrm[0][0] > nrm[1][1] && nrm[0][0] > nrm[2][2]) begin
            br    = BR_X;
            arg   = ONE_WORK + nrm[0][0] - nrm[1][1] - nrm[2][2];
            root  = floor_root(arg > 0 ? 64'(arg) << 30 : 64'd0);
            twice = root << 1;
            quat[0] = longint'(root >> 1);
            quat[1] = q30_quotient(nrm[0][1] + nrm[1][0], twice);
            quat[2] = q30_quotient(nrm[2][0] + nrm[0][2], twice);
            quat[3] = q30_quotient(nrm[1][2] - nrm[2][1], twice);
         end else if (nrm[1][1] > nrm[2][2]) begin
            br    = BR_Y;
            arg   = ONE_WORK + nrm[1][1] - nrm[0][0] - nrm[2][2];
            root  = floor_root(arg > 0 ? 64'(arg) << 30 : 64'd0);
            twice = root << 1;
            quat[0] = q30_quotient(nrm[0][1] + nrm[1][0], twice);
            quat[1] = longint'(root >> 1);
            quat[2] = q30_quotient(nrm[1][2] + nrm[2][1], twice);
            quat[3] = q30_quotient(nrm[2][0] - nrm[0][2], twice);
         end else begin
            br    = BR_Z;
            arg   = ONE_WORK + nrm[2][2] - nrm[0][0] - nrm[1][1];
            root  = floor_root(arg > 0 ? 64'(arg) << 30 : 64'd0);
            twice = root << 1;
            quat[0] = q30_quotient(nrm[2][0] + nrm[0][2], twice);
            quat[1] = q30_quotient(nrm[1][2] + nrm[2][1], twice);
            quat[2] = longint'(root >> 1);
            quat[3] = q30_quotient(nrm[0][1] - nrm[1][0], twice);
         end
      end
      res.trans_x = mx[9];
      res.trans_y = mx[10];
      res.trans_z = mx[11];
      res.scale_x = row_len[0][31:0];
      res.scale_y = row_len[1][31:0];
      res.scale_z = row_len[2][31:0];
      res.quat_x  = quat_field(quat[0]);
      res.quat_y  = quat_field(quat[1]);
      res.quat_z  = quat_field(quat[2]);
      res.quat_w  = quat_field(quat[3]);
      res.degenerate = flat;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request side: one transaction, then maybe a burst of idle cycles
   // ------------------------------------------------------------------
   task automatic send_matrix(input matrix_type mx);
      decomposition_type exp_res;
      branch_type br;
      req_valid <= 1'b1;
      for (int i = 0; i < 12; i++) req_field[i] <= mx[i];
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: record what must come out
      exp_res = decompose(mx, br);
      pending_results.push_back(exp_res);
      matrices_sent++;
      if (exp_res.degenerate) degenerate_seen++;
      else branch_hits[br]++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // response side: random stall bursts on rsp_ready
   // ------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else if (idle_on && !reset && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
         rsp_ready <= (stall_left == 0) && !reset;
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      end
   endtask

   // every accepted result is compared with the oldest pending one
   always @(posedge clock) begin
      decomposition_type exp_res;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result transaction with nothing pending", $time);
         end else begin
            exp_res = pending_results.pop_front();
            results_checked++;
            check_field("trans_x", exp_res.trans_x, rsp_trans_x);
            check_field("trans_y", exp_res.trans_y, rsp_trans_y);
            check_field("trans_z", exp_res.trans_z, rsp_trans_z);
            check_field("scale_x", exp_res.scale_x, rsp_scale_x);
            check_field("scale_y", exp_res.scale_y, rsp_scale_y);
            check_field("scale_z", exp_res.scale_z, rsp_scale_z);
            check_field("quat_x", exp_res.quat_x, rsp_quat_x);
            check_field("quat_y", exp_res.quat_y, rsp_quat_y);
            check_field("quat_z", exp_res.quat_z, rsp_quat_z);
            check_field("quat_w", exp_res.quat_w, rsp_quat_w);
            check_field("degenerate", 32'(exp_res.degenerate), 32'(rsp_degenerate));
         end
      end
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------

   // scaled signed permutation: a pure rotation or reflection with noise
   function automatic matrix_type rotation_like(input int noise);
      matrix_type mx;
      int perm [3];
      int tmp, k;
      logic signed [31:0] scl;
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         k = $urandom_range(0, i);
         tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
      end
      for (int i = 0; i < 3; i++) begin
         scl = $urandom_range(1, 8) << $urandom_range(10, 18);
         for (int j = 0; j < 3; j++) begin
            mx[i*3+j] = $signed($urandom_range(0, 2*noise)) - noise;
            if (j == perm[i]) mx[i*3+j] += $urandom_range(0, 1) ? scl : -scl;
         end
      end
      for (int i = 9; i < 12; i++) mx[i] = $urandom;
      return mx;
   endfunction

   function automatic matrix_type raw_matrix();
      matrix_type mx;
      int shift;
      shift = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(8, 31);
      for (int i = 0; i < 12; i++) mx[i] = $signed($urandom) >>> shift;
      // occasionally flatten one row
      if ($urandom_range(0, 15) == 0) begin
         k_flat: begin
            int r;
            r = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++) mx[r*3+j] = 0;
         end
      end
      return mx;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // identity, half turns about each axis, flat rows, field extremes
   task automatic test_directed();
      matrix_type mx;
      localparam logic signed [31:0] ONE = 32'sh0001_0000;
      localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
      localparam logic signed [31:0] MINV = 32'sh8000_0000;
      mx = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0};
      send_matrix(mx);
      mx = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1, 2, 3};           // about x
      send_matrix(mx);
      mx = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, -1, -2, -3};        // about y
      send_matrix(mx);
      mx = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, MAXV, MINV, 0};     // about z
      send_matrix(mx);
      mx = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 0, 0, 0};          // reflection
      send_matrix(mx);
      mx = '{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE, 5, 6, 7};            // tie on diagonal
      send_matrix(mx);
      mx = '{0, 0, 0, 0, ONE, 0, 0, 0, ONE, 8, 9, 10};              // flat row 0
      send_matrix(mx);
      mx = '{ONE, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0, 0};               // flat row 1
      send_matrix(mx);
      mx = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0};               // flat row 2
      send_matrix(mx);
      mx = '{0, 0, 0, 0, 0, 0, 0, 0, 0, MINV, MAXV, -1};            // all flat
      send_matrix(mx);
      mx = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
      send_matrix(mx);
      mx = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};
      send_matrix(mx);
      mx = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, -1, -1, -1};
      send_matrix(mx);
      mx = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};                   // tiny rows
      send_matrix(mx);
      mx = '{-1, -1, -1, 1, 1, 1, -1, 1, -1, 0, 0, 0};              // non-orthogonal
      send_matrix(mx);
      mx = '{ONE, ONE, 0, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0};        // 45 deg about z
      send_matrix(mx);
   endtask

   task automatic test_rotations(input int count);
      matrix_type mx;
      for (int n = 0; n < count; n++) begin
         mx = rotation_like($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4000));
         send_matrix(mx);
      end
   endtask

   task automatic test_raw(input int count);
      for (int n = 0; n < count; n++) send_matrix(raw_matrix());
   endtask

   // back-to-back transactions with both sides always ready
   task automatic test_full_rate(input int count);
      idle_on = 1'b0;
      for (int n = 0; n < count; n++)
         send_matrix($urandom_range(0, 1) ? rotation_like(50) : raw_matrix());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_rotations(330);
      test_raw(300);
      test_full_rate(110);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d matrices, %0d results checked, %0d degenerate",
               matrices_sent, results_checked, degenerate_seen);
      $display("branches: trace %0d, x %0d, y %0d, z %0d",
               branch_hits[BR_TRACE], branch_hits[BR_X], branch_hits[BR_Y],
               branch_hits[BR_Z]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
